>>> hw/rtl/pett_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_pkg: shared types and codes of the periodic event timer table
// Command and result codes, the slot entry layout kept in the slot memory,
// and the result record that travels from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package pett_pkg;

  // Command codes carried on the request selector
  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  // One slot as stored in the slot memory
  typedef struct packed {
    logic        notify;
    logic [15:0] fire_count;
    logic [15:0] tick_count;
    logic [15:0] repeat_target;
    logic [15:0] period;
  } slot_entry_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic       status;
    logic [4:0] slot;
    logic       fired;
    logic       released;
    logic       release_notify;
    logic       last;
  } result_t;

endpackage

>>> hw/rtl/periodic_event_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_timer_table: table of repeating timer slots
// Register, tick and clear requests over a stream port; replies, slot events
// and done markers over a stream port; forever code set by a write channel.
// ----------------------------------------------------------------------------
// Slot parameters and counters live in one synchronous RAM of SLOTS entries;
// only the active bits are flip-flops, so no clearing pass follows reset.
// A register or clear request passes through a reply or done state before its
// result is queued. A tick walks the slots in index order: a free slot is
// skipped, an active slot is read from RAM, then updated and written back,
// and a done item follows the last slot; result stalls can hold the walk.
// Requests are taken one at a time; results pass through a two-entry output
// queue, so a finished result may wait while the next request is accepted.
// ----------------------------------------------------------------------------
module periodic_event_timer_table import pett_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request: tuser = opcode[1:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: period[15:0], repeat_count[31:16], notify_on_release[32], zero fill
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  // result: tuser = kind[1:0], tlast = last
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: status[0], slot[5:1], fired[6], released[7], release_notify[8]
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  // forever code write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_REPLY,
    ST_DONE
  } state_t;

  state_t      state;
  logic [SW-1:0] idx;
  logic [SLOTS-1:0] active;
  logic [15:0] forever_count;
  result_t     reply;

  // output queue: staging entry and output register
  result_t     res;
  logic        res_valid;
  result_t     m_out;

  logic        m_free;
  logic        can_put;
  logic        put;
  result_t     put_res;

  logic        free_found;
  logic [SW-1:0] free_idx;

  logic        ram_we;
  logic [SW-1:0] ram_waddr;
  slot_entry_t ram_wdata;
  logic        ram_re;
  slot_entry_t ram_rdata;

  slot_entry_t step_nxt;
  logic        step_fired;
  logic        step_released;
  logic        step_event;
  slot_entry_t new_entry;

  logic        accept;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign m_tdata = {7'd0, m_out.release_notify, m_out.released, m_out.fired,
                    m_out.slot, m_out.status};
  assign m_tuser = m_out.kind;
  assign m_tlast = m_out.last;

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Fresh entry for a register request
  always_comb begin
    new_entry.notify        = s_tdata[32];
    new_entry.fire_count    = 16'd0;
    new_entry.tick_count    = 16'd0;
    new_entry.repeat_target = s_tdata[31:16];
    new_entry.period        = s_tdata[15:0];
  end

  pett_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (SLOTS),
    .AW    (SW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  pett_slot_step u_step (
    .cur           (ram_rdata),
    .forever_count (forever_count),
    .nxt           (step_nxt),
    .fired         (step_fired),
    .released      (step_released)
  );

  assign step_event = step_fired || step_released;
  assign m_free     = !m_tvalid || m_tready;
  assign can_put    = !res_valid || m_free;

  // Drive RAM accesses and result production from the current state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = step_nxt;
    ram_re    = 1'b0;
    put       = 1'b0;
    put_res   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser == OP_REGISTER && free_found) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = new_entry;
        end
      end
      ST_READ: begin
        ram_re = active[idx];
      end
      ST_UPDATE: begin
        if (!step_event || can_put) begin
          ram_we = 1'b1;
          put    = step_event;
        end
        put_res.kind           = KIND_EVENT;
        put_res.slot           = 5'(idx);
        put_res.fired          = step_fired;
        put_res.released       = step_released;
        put_res.release_notify = step_released && ram_rdata.notify;
      end
      ST_REPLY: begin
        put     = can_put;
        put_res = reply;
      end
      ST_DONE: begin
        put          = can_put;
        put_res.kind = KIND_DONE;
        put_res.last = 1'b1;
      end
      default: begin
        put = 1'b0;
      end
    endcase
  end

  // Sequencer, slot active bits, forever code and output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      active        <= '0;
      forever_count <= 16'hFFFF;
      res_valid     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        forever_count <= cfg_data;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              OP_REGISTER: begin
                if (free_found) begin
                  active[free_idx] <= 1'b1;
                end
                reply <= '{kind: KIND_REPLY,
                           status: !free_found,
                           slot: free_found ? 5'(free_idx) : 5'd0,
                           fired: 1'b0,
                           released: 1'b0,
                           release_notify: 1'b0,
                           last: 1'b1};
                state <= ST_REPLY;
              end
              OP_TICK: begin
                idx   <= '0;
                state <= ST_READ;
              end
              OP_CLEAR: begin
                active <= '0;
                state  <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          if (active[idx]) begin
            state <= ST_UPDATE;
          end else if (idx == LAST_IDX) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + SW'(1);
          end
        end
        ST_UPDATE: begin
          if (!step_event || can_put) begin
            if (step_released) begin
              active[idx] <= 1'b0;
            end
            if (idx == LAST_IDX) begin
              state <= ST_DONE;
            end else begin
              idx   <= idx + SW'(1);
              state <= ST_READ;
            end
          end
        end
        ST_REPLY, ST_DONE: begin
          if (can_put) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Advance the output queue
      if (m_free) begin
        if (res_valid) begin
          m_tvalid  <= 1'b1;
          m_out     <= res;
          res_valid <= put;
          if (put) begin
            res <= put_res;
          end
        end else if (put) begin
          m_tvalid <= 1'b1;
          m_out    <= put_res;
        end else begin
          m_tvalid <= 1'b0;
        end
      end else if (put) begin
        res_valid <= 1'b1;
        res       <= put_res;
      end
    end
  end

  // A staged result holds while the output register is blocked
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && m_tvalid && !m_tready |=> res_valid && $stable(res))
    else $error("staged result lost or changed while output stalled");

  // A clear request leaves every slot free
  a_clear_frees: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == OP_CLEAR |=> active == '0)
    else $error("slots still active after clear");

  // Tick write-back only touches the slot being walked, which is active
  a_writeback_active: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && ram_we |-> active[idx] && ram_waddr == idx)
    else $error("write-back to an inactive or wrong slot");

  // Never accept a request while a tick walk is in progress
  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_UPDATE) |-> !s_tready)
    else $error("request accepted during tick walk");

endmodule

>>> hw/rtl/pett_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module pett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/pett_slot_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_slot_step: one tick applied to one slot entry
// Advances the tick counter, fires at the period, counts firings and decides
// release against the repeat target and the forever code.
// ----------------------------------------------------------------------------
module pett_slot_step import pett_pkg::*; (
  input  slot_entry_t cur,
  input  logic [15:0] forever_count,
  output slot_entry_t nxt,
  output logic        fired,
  output logic        released
);

  logic [15:0] tick_inc;
  logic [15:0] fire_inc;
  logic        hit;

  // Advance counters, then check the repeat target
  always_comb begin
    tick_inc = cur.tick_count + 16'd1;
    fired    = (tick_inc == cur.period);
    fire_inc = fired ? (cur.fire_count + 16'd1) : cur.fire_count;
    hit      = (fire_inc == cur.repeat_target);
    released = hit && (fire_inc != forever_count);

    nxt            = cur;
    nxt.tick_count = fired ? 16'd0 : tick_inc;
    nxt.fire_count = hit ? 16'd0 : fire_inc;
  end

endmodule

>>> test/timer_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_table_checker: result predictor and comparator for the timer table
// Watches the request, result and forever-code channels. Every accepted
// request advances a private copy of the slot table and queues the results
// it must cause; every accepted result is compared field by field with the
// oldest queued one. Mismatches and the number of results still owed are
// handed back to the test top.
// ----------------------------------------------------------------------------
module timer_table_checker import pett_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // tdata: period[15:0], repeat_count[31:16], notify_on_release[32], zero fill
  input  logic [39:0] s_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // tdata: status[0], slot[5:1], fired[6], released[7], release_notify[8]
  input  logic [15:0] m_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          results_owed
);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Private copy of the table
  slot_entry_t slot_table [SLOTS];
  logic        slot_busy  [SLOTS];
  logic [15:0] forever_code;

  // Results owed by the block, oldest first
  result_t awaited_results [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: result %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Advance the table by one request and queue the results it causes
  task automatic advance_table(input logic [1:0] op, input logic [15:0] period,
                               input logic [15:0] repeat_count, input logic notify);
    result_t note;
    logic    placed;
    logic    fired;
    logic    freed;
    int      i;
    note   = '0;
    placed = 1'b0;
    case (op)
      OP_REGISTER: begin
        note.kind   = KIND_REPLY;
        note.last   = 1'b1;
        note.status = STATUS_FULL;
        for (i = 0; i < SLOTS; i++) begin
          if (!placed && !slot_busy[i]) begin
            placed                         = 1'b1;
            slot_busy[i]                   = 1'b1;
            slot_table[i].period           = period;
            slot_table[i].repeat_target    = repeat_count;
            slot_table[i].tick_count       = '0;
            slot_table[i].fire_count       = '0;
            slot_table[i].notify           = notify;
            note.status                    = STATUS_OK;
            note.slot                      = 5'(i);
          end
        end
        awaited_results.push_back(note);
      end
      OP_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_busy[i]) begin
            fired = 1'b0;
            freed = 1'b0;
            slot_table[i].tick_count = slot_table[i].tick_count + 16'd1;
            if (slot_table[i].tick_count == slot_table[i].period) begin
              fired                    = 1'b1;
              slot_table[i].tick_count = '0;
              slot_table[i].fire_count = slot_table[i].fire_count + 16'd1;
            end
            // Completed a round of repeats: free the slot unless it runs forever
            if (slot_table[i].fire_count == slot_table[i].repeat_target) begin
              if (slot_table[i].fire_count != forever_code) begin
                slot_busy[i] = 1'b0;
                freed        = 1'b1;
              end
              slot_table[i].fire_count = '0;
            end
            if (fired || freed) begin
              note                = '0;
              note.kind           = KIND_EVENT;
              note.slot           = 5'(i);
              note.fired          = fired;
              note.released       = freed;
              note.release_notify = freed ? slot_table[i].notify : 1'b0;
              awaited_results.push_back(note);
            end
          end
        end
        note      = '0;
        note.kind = KIND_DONE;
        note.last = 1'b1;
        awaited_results.push_back(note);
      end
      default: begin
        if (op == OP_CLEAR) begin
          for (i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
        end
        note.kind = KIND_DONE;
        note.last = 1'b1;
        awaited_results.push_back(note);
      end
    endcase
  endtask

  // Compare one accepted result with the oldest one owed
  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("unexpected", int'(m_tuser), -1);
    end else begin
      want = awaited_results.pop_front();
      if (m_tuser != want.kind)
        report_mismatch("kind", int'(m_tuser), int'(want.kind));
      if (m_tdata[0] != want.status)
        report_mismatch("status", int'(m_tdata[0]), int'(want.status));
      if (m_tdata[5:1] != want.slot)
        report_mismatch("slot", int'(m_tdata[5:1]), int'(want.slot));
      if (m_tdata[6] != want.fired)
        report_mismatch("fired", int'(m_tdata[6]), int'(want.fired));
      if (m_tdata[7] != want.released)
        report_mismatch("released", int'(m_tdata[7]), int'(want.released));
      if (m_tdata[8] != want.release_notify)
        report_mismatch("release_notify", int'(m_tdata[8]), int'(want.release_notify));
      if (m_tlast != want.last)
        report_mismatch("last", int'(m_tlast), int'(want.last));
    end
  endtask

  // Drain results first, then take in the new request and forever code
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
      forever_code = 16'hFFFF;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready)
        advance_table(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[32]);
      if (cfg_valid && cfg_ready) forever_code = cfg_data;
    end
    results_owed <= awaited_results.size();
  end

endmodule

>>> test/periodic_event_timer_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_timer_table_test: stimulus and verdict for the timer table
// Runs a directed sequence over full table, release, forever and wrap cases,
// then random request phases under several forever codes with random gaps on
// the request side and random stalls on the result side. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module periodic_event_timer_table_test;
  import pett_pkg::*;

  localparam int         SLOTS          = 8;
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         PHASES         = 5;
  localparam int         PHASE_ITEMS    = 27;
  localparam int         SETTLE_CYCLES  = 4 * SLOTS;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // tdata: period[15:0], repeat_count[31:16], notify_on_release[32], zero fill
  logic [39:0] s_tdata;
  // tuser: opcode[1:0]
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // tdata: status[0], slot[5:1], fired[6], released[7], release_notify[8]
  logic [15:0] m_tdata;
  // tuser: kind[1:0]
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int          mismatches;
  int          results_owed;
  int          stall_chance;
  int          stall_left;
  int          gap_chance;
  int          quiet_cycles;
  logic [15:0] forever_now;

  periodic_event_timer_table #(.SLOTS(SLOTS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  timer_table_checker #(.SLOTS(SLOTS)) i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (rst || stall_chance == 0) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(1, 100) <= stall_chance) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // End the run when no channel has moved for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL periodic_event_timer_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold one request until the block takes it; valid stays up for the next
  task automatic send_request(input logic [1:0] op, input logic [15:0] period,
                              input logic [15:0] repeat_count, input logic notify);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, notify, repeat_count, period};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic request_gap();
    if (gap_chance != 0 && $urandom_range(1, 100) <= gap_chance) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every owed result has arrived and the block settles
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_forever(input logic [15:0] code);
    cfg_valid   <= 1'b1;
    cfg_data    <= code;
    forever_now  = code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small periods and repeat counts so slots fire and free often
  task automatic send_random();
    logic [1:0]  op;
    logic [15:0] period;
    logic [15:0] repeat_count;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = OP_REGISTER;
    else if (pick < 88) op = OP_TICK;
    else if (pick < 95) op = OP_CLEAR;
    else                op = OP_UNUSED;
    period       = 16'($urandom);
    repeat_count = 16'($urandom);
    if (op == OP_REGISTER) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       period = 16'($urandom_range(1, 4));
      else if (pick == 7) period = 16'h0000;
      else if (pick == 9) period = 16'hFFFF;
      pick = $urandom_range(0, 9);
      if (pick < 6)       repeat_count = 16'($urandom_range(0, 4));
      else if (pick == 6) repeat_count = forever_now;
      else if (pick == 8) repeat_count = 16'hFFFF;
    end
    request_gap();
    send_request(op, period, repeat_count, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [15:0] phase_codes [PHASES];
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= OP_TICK;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    stall_chance <= 0;
    gap_chance    = 0;
    forever_now   = 16'hFFFF;
    phase_codes   = '{16'h0000, 16'h0001, 16'h0002, 16'h0000, 16'hFFFF};
    phase_codes[3] = 16'($urandom);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill the table, overflow it, fire, release, reuse, clear
    stall_chance <= 30;
    gap_chance    = 30;
    send_request(OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(OP_REGISTER, 16'd1, 16'd3, 1'b1);
    // repeat count zero: freed on the first tick
    send_request(OP_REGISTER, 16'd2, 16'd0, 1'b1);
    // period zero: fires only on counter wrap
    send_request(OP_REGISTER, 16'd0, 16'd1, 1'b0);
    send_request(OP_REGISTER, 16'hFFFF, 16'hFFFF, 1'b0);
    request_gap();
    send_request(OP_REGISTER, 16'd1, 16'd1, 1'b1);
    send_request(OP_REGISTER, 16'd3, 16'd2, 1'b1);
    // repeat count equal to the forever code: fires every tick, never freed
    send_request(OP_REGISTER, 16'd1, 16'hFFFF, 1'b1);
    send_request(OP_REGISTER, 16'd2, 16'd1, 1'b0);
    // table full
    send_request(OP_REGISTER, 16'd5, 16'd5, 1'b1);
    repeat (6) begin
      request_gap();
      send_request(OP_TICK, 16'h0000, 16'h0000, 1'b0);
    end
    send_request(OP_REGISTER, 16'd2, 16'd2, 1'b0);
    send_request(OP_TICK, 16'hA5A5, 16'h5A5A, 1'b1);
    send_request(OP_CLEAR, 16'h0000, 16'h0000, 1'b0);
    send_request(OP_TICK, 16'h0000, 16'h0000, 1'b0);
    send_request(OP_REGISTER, 16'h5A5A, 16'hA5A5, 1'b1);
    send_request(OP_REGISTER, 16'hA5A5, 16'h5A5A, 1'b0);
    send_request(OP_CLEAR, 16'h0000, 16'h0000, 1'b0);

    // Random phases, one forever code each; the last one runs without idling
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      write_forever(phase_codes[phase]);
      if (phase == PHASES - 1) begin
        stall_chance <= 0;
        gap_chance    = 0;
      end else begin
        stall_chance <= (phase == 1) ? 0 : 10 * $urandom_range(1, 4);
        gap_chance    = (phase == 2) ? 0 : 10 * $urandom_range(1, 4);
      end
      repeat (PHASE_ITEMS) send_random();
    end

    wait_drained();
    @(negedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("PASS periodic_event_timer_table");
    end else begin
      $display("FAIL periodic_event_timer_table");
    end
    $finish;
  end

endmodule
